// ----- src/sorted_sparse_histogram_binner_top_assert.svh -----
// Assertion macros for the sorted sparse histogram binner
`ifndef SORTED_SPARSE_HISTOGRAM_BINNER_TOP_ASSERT_SVH
`define SORTED_SPARSE_HISTOGRAM_BINNER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SSHB_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SSHB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/sshb_pkg.sv -----
// Package with shared constants and types of the sorted sparse histogram binner
`timescale 1ns / 1ps
`default_nettype none
package sshb_pkg;
   localparam int MAX_BINS  = 4096;
   localparam int CHANNELS  = 2;
   localparam int ADDR_W    = 12;
   localparam int USED_W    = $clog2(MAX_BINS + 1);
   localparam int SAMPLE_W  = 16;
   localparam int CENTER_W  = 18;
   localparam int KEY_W     = 2 * CENTER_W;
   localparam int COUNT_W   = 32;
   localparam int ENTRY_W   = KEY_W + COUNT_W;
   localparam int DIV_STEPS = SAMPLE_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam logic [CENTER_W-1:0] CENTER_BIAS = {1'b1, {(CENTER_W-1){1'b0}}};
   localparam logic [COUNT_W-1:0]  COUNT_MAX   = '1;

   localparam logic CSR_BIN_SIZE_A = 1'b0;
   localparam logic CSR_BIN_SIZE_B = 1'b1;

   localparam logic KIND_ADD  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_SRCH_ADDR,
      ST_SRCH_CMP,
      ST_SH_RD,
      ST_SH_WR,
      ST_INS,
      ST_RD_ADDR,
      ST_RD_DATA,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

// ----- src/sorted_sparse_histogram_binner_top.sv -----
// Sorted sparse histogram binner: one item at a time through divider, search and insert
//
// Each request is worked on alone; ready is high only while the block is idle.
// An add request runs a shared bit-serial divider for channel a and then channel b,
// a binary search over the sorted table held in one RAM with registered read (up to
// 13 probes), and for a new bin an insertion that moves each later entry up one place
// before the new entry is written. A read request past the bins in use goes straight
// to its result without reading the table. A result that cannot leave because the
// previous one still waits holds the block for as long. One result is returned per
// request; the next request is taken while a result still waits on the response side.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_sparse_histogram_binner_top_assert.svh"
module sorted_sparse_histogram_binner_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // sample_a, sample_b, read_index, zero pad
   input  wire logic        req_tuser,  // kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [95:0] rsp_tdata,  // position, center_a, center_b, bin_count,
                                        // bins_used, zero pad
   output logic      [2:0]  rsp_tuser,  // is_new, status
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);
   localparam int AW = sshb_pkg::ADDR_W;
   localparam int UW = sshb_pkg::USED_W;
   localparam int CW = sshb_pkg::CENTER_W;
   localparam int SW = sshb_pkg::SAMPLE_W;
   localparam int NW = sshb_pkg::COUNT_W;
   localparam int KW = sshb_pkg::KEY_W;

   sshb_pkg::state_type state_ff, state_in;

   logic [SW-1:0] size_a_ff, size_b_ff;
   logic          kind_ff;
   logic [SW-1:0] samp_a_ff, samp_b_ff;
   logic [AW-1:0] idx_ff;

   logic              chan_ff, chan_in;
   logic [sshb_pkg::STEP_W-1:0] step_ff, step_in;
   logic [SW-1:0]     mag_ff, mag_in, rem_ff, rem_in;
   logic [CW-1:0]     ca_ff, ca_in, cb_ff, cb_in;
   logic [UW-1:0]     lo_ff, lo_in, hi_ff, hi_in, ptr_ff, ptr_in, used_ff, used_in;
   logic [AW-1:0]     mid_ff, mid_in;

   logic [AW-1:0]     res_pos_ff, res_pos_in;
   logic [CW-1:0]     res_ca_ff, res_ca_in, res_cb_ff, res_cb_in;
   logic [NW-1:0]     res_cnt_ff, res_cnt_in;
   logic              res_new_ff, res_new_in;
   sshb_pkg::status_type res_st_ff, res_st_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [sshb_pkg::ENTRY_W-1:0] mem_wdata, mem_rdata;

   logic          req_fire, slot_free;
   logic [SW-1:0] cur_samp, cur_size, div_d, cur_mag, qb_mag;
   logic [SW:0]   trial;
   logic [SW-1:0] rem_next;
   logic [CW-1:0] qb_s, centre;
   logic [KW-1:0] key, rd_key;
   logic [NW-1:0] rd_cnt, inc_cnt;
   logic [UW:0]   mid_sum;

   assign req_fire  = req_tvalid && req_tready;
   assign slot_free = !rsp_tvalid || rsp_tready;

   // Serial divider datapath: one remainder bit per cycle
   assign cur_samp = chan_ff ? samp_b_ff : samp_a_ff;
   assign cur_size = chan_ff ? size_b_ff : size_a_ff;
   assign div_d    = (cur_size == '0) ? SW'(1) : cur_size;
   assign cur_mag  = cur_samp[SW-1] ? SW'(-cur_samp) : cur_samp;
   assign trial    = {rem_ff, mag_ff[SW-1]};
   assign rem_next = (trial >= {1'b0, div_d}) ? SW'(trial - {1'b0, div_d}) : trial[SW-1:0];
   assign qb_mag   = cur_mag - rem_next;
   assign qb_s     = cur_samp[SW-1] ? CW'(-{2'b00, qb_mag}) : {2'b00, qb_mag};
   assign centre   = CW'({qb_s[CW-2:0], 1'b0}) + CW'(div_d);

   assign key      = {ca_ff ^ sshb_pkg::CENTER_BIAS, cb_ff ^ sshb_pkg::CENTER_BIAS};
   assign rd_key   = mem_rdata[sshb_pkg::ENTRY_W-1:NW];
   assign rd_cnt   = mem_rdata[NW-1:0];
   assign inc_cnt  = (rd_cnt == sshb_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + NW'(1);
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};

   sshb_ram #(
      .WIDTH (sshb_pkg::ENTRY_W),
      .DEPTH (sshb_pkg::MAX_BINS)
   ) u_table (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sshb_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == sshb_pkg::KIND_ADD) begin
                  state_in = sshb_pkg::ST_DIV;
               end else if ({1'b0, req_tdata[43:32]} < used_ff) begin
                  state_in = sshb_pkg::ST_RD_ADDR;
               end else begin
                  state_in = sshb_pkg::ST_DONE;
               end
            end
         end
         sshb_pkg::ST_DIV: begin
            if (step_ff == sshb_pkg::STEP_W'(sshb_pkg::DIV_STEPS - 1)
                && (chan_ff || sshb_pkg::CHANNELS < 2)) begin
               state_in = sshb_pkg::ST_SRCH_ADDR;
            end
         end
         sshb_pkg::ST_SRCH_ADDR: begin
            if (lo_ff < hi_ff) begin
               state_in = sshb_pkg::ST_SRCH_CMP;
            end else if (used_ff == UW'(sshb_pkg::MAX_BINS)) begin
               state_in = sshb_pkg::ST_DONE;
            end else if (used_ff > lo_ff) begin
               state_in = sshb_pkg::ST_SH_RD;
            end else begin
               state_in = sshb_pkg::ST_INS;
            end
         end
         sshb_pkg::ST_SRCH_CMP: begin
            state_in = (rd_key == key) ? sshb_pkg::ST_DONE : sshb_pkg::ST_SRCH_ADDR;
         end
         sshb_pkg::ST_SH_RD: state_in = sshb_pkg::ST_SH_WR;
         sshb_pkg::ST_SH_WR: begin
            state_in = (ptr_ff - UW'(1) > lo_ff) ? sshb_pkg::ST_SH_RD : sshb_pkg::ST_INS;
         end
         sshb_pkg::ST_INS:     state_in = sshb_pkg::ST_DONE;
         sshb_pkg::ST_RD_ADDR: state_in = sshb_pkg::ST_RD_DATA;
         sshb_pkg::ST_RD_DATA: state_in = sshb_pkg::ST_DONE;
         sshb_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = sshb_pkg::ST_IDLE;
            end
         end
         default: state_in = sshb_pkg::ST_IDLE;
      endcase
   end

   // Handshake and table port controls
   always_comb begin
      req_tready = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = mid_ff;
      mem_wdata  = {key, inc_cnt};
      mem_raddr  = mid_sum[AW:1];
      case (state_ff)
         sshb_pkg::ST_IDLE:      req_tready = 1'b1;
         sshb_pkg::ST_SRCH_ADDR: mem_raddr  = mid_sum[AW:1];
         sshb_pkg::ST_SRCH_CMP:  mem_we     = (rd_key == key);
         sshb_pkg::ST_SH_RD:     mem_raddr  = AW'(ptr_ff - UW'(1));
         sshb_pkg::ST_SH_WR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff[AW-1:0];
            mem_wdata = mem_rdata;
         end
         sshb_pkg::ST_INS: begin
            mem_we    = 1'b1;
            mem_waddr = lo_ff[AW-1:0];
            mem_wdata = {key, NW'(1)};
         end
         sshb_pkg::ST_RD_ADDR:   mem_raddr  = idx_ff;
         default:                mem_raddr  = idx_ff;
      endcase
   end

   // Datapath next values
   always_comb begin
      chan_in    = chan_ff;
      step_in    = step_ff;
      mag_in     = mag_ff;
      rem_in     = rem_ff;
      ca_in      = ca_ff;
      cb_in      = cb_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      ptr_in     = ptr_ff;
      used_in    = used_ff;
      res_pos_in = res_pos_ff;
      res_ca_in  = res_ca_ff;
      res_cb_in  = res_cb_ff;
      res_cnt_in = res_cnt_ff;
      res_new_in = res_new_ff;
      res_st_in  = res_st_ff;
      case (state_ff)
         sshb_pkg::ST_IDLE: begin
            chan_in    = 1'b0;
            step_in    = '0;
            rem_in     = '0;
            mag_in     = req_tdata[15] ? SW'(-req_tdata[15:0]) : req_tdata[15:0];
            res_pos_in = req_tdata[43:32];
            res_ca_in  = '0;
            res_cb_in  = '0;
            res_cnt_in = '0;
            res_new_in = 1'b0;
            res_st_in  = sshb_pkg::STATUS_RANGE;
         end
         sshb_pkg::ST_DIV: begin
            step_in = step_ff + sshb_pkg::STEP_W'(1);
            rem_in  = rem_next;
            mag_in  = {mag_ff[SW-2:0], 1'b0};
            if (step_ff == sshb_pkg::STEP_W'(sshb_pkg::DIV_STEPS - 1)) begin
               rem_in = '0;
               if (!chan_ff) begin
                  ca_in   = centre;
                  cb_in   = '0;
                  chan_in = 1'b1;
                  mag_in  = samp_b_ff[SW-1] ? SW'(-samp_b_ff) : samp_b_ff;
               end else begin
                  cb_in = centre;
               end
               lo_in = '0;
               hi_in = used_ff;
            end
         end
         sshb_pkg::ST_SRCH_ADDR: begin
            mid_in     = mid_sum[AW:1];
            res_ca_in  = ca_ff;
            res_cb_in  = cb_ff;
            res_pos_in = '0;
            res_cnt_in = '0;
            res_st_in  = sshb_pkg::STATUS_FULL;
            ptr_in     = used_ff;
         end
         sshb_pkg::ST_SRCH_CMP: begin
            if (rd_key < key) begin
               lo_in = UW'(mid_ff) + UW'(1);
            end else if (rd_key > key) begin
               hi_in = UW'(mid_ff);
            end else begin
               res_pos_in = mid_ff;
               res_cnt_in = inc_cnt;
               res_st_in  = sshb_pkg::STATUS_OK;
            end
         end
         sshb_pkg::ST_SH_WR: ptr_in = ptr_ff - UW'(1);
         sshb_pkg::ST_INS: begin
            used_in    = used_ff + UW'(1);
            res_pos_in = lo_ff[AW-1:0];
            res_cnt_in = NW'(1);
            res_new_in = 1'b1;
            res_st_in  = sshb_pkg::STATUS_OK;
         end
         sshb_pkg::ST_RD_DATA: begin
            res_ca_in  = rd_key[KW-1:CW] ^ sshb_pkg::CENTER_BIAS;
            res_cb_in  = (sshb_pkg::CHANNELS < 2) ? '0 : rd_key[CW-1:0] ^ sshb_pkg::CENTER_BIAS;
            res_cnt_in = rd_cnt;
            res_st_in  = sshb_pkg::STATUS_OK;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sshb_pkg::ST_IDLE;
         used_ff    <= '0;
         size_a_ff  <= SW'(1);
         size_b_ff  <= SW'(1);
         rsp_tvalid <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         if (csr_we && csr_index == sshb_pkg::CSR_BIN_SIZE_A) begin
            size_a_ff <= csr_wdata;
         end
         if (csr_we && csr_index == sshb_pkg::CSR_BIN_SIZE_B) begin
            size_b_ff <= csr_wdata;
         end
         // Hold the result until transfer, load the next when the slot frees
         if (state_ff == sshb_pkg::ST_DONE && slot_free) begin
            rsp_tvalid <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff   <= req_tuser;
         samp_a_ff <= req_tdata[15:0];
         samp_b_ff <= req_tdata[31:16];
         idx_ff    <= req_tdata[43:32];
      end
      chan_ff    <= chan_in;
      step_ff    <= step_in;
      mag_ff     <= mag_in;
      rem_ff     <= rem_in;
      ca_ff      <= ca_in;
      cb_ff      <= cb_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      ptr_ff     <= ptr_in;
      res_pos_ff <= res_pos_in;
      res_ca_ff  <= res_ca_in;
      res_cb_ff  <= res_cb_in;
      res_cnt_ff <= res_cnt_in;
      res_new_ff <= res_new_in;
      res_st_ff  <= res_st_in;
      if (state_ff == sshb_pkg::ST_DONE && slot_free) begin
         rsp_tdata <= {3'b000, used_ff, res_cnt_ff, res_cb_ff, res_ca_ff, res_pos_ff};
         rsp_tuser <= {res_st_ff, res_new_ff && (kind_ff == sshb_pkg::KIND_ADD)};
      end
   end

   `SSHB_ASSERT_NOW(a_used_bound, 1'b1, used_ff <= UW'(sshb_pkg::MAX_BINS), "bins in use beyond table size")
   `SSHB_ASSERT_NOW(a_used_step, !$past(reset) && used_ff != $past(used_ff), used_ff == $past(used_ff) + UW'(1), "bins in use moved by more than one")
   `SSHB_ASSERT_NOW(a_new_ok, rsp_tvalid && rsp_tuser[0], rsp_tuser[2:1] == sshb_pkg::STATUS_OK, "new bin flagged with a failing status")
   `SSHB_ASSERT_NOW(a_shift_above_lo, state_ff == sshb_pkg::ST_SH_RD || state_ff == sshb_pkg::ST_SH_WR, ptr_ff > lo_ff, "shift pointer at or below insert place")
endmodule
`default_nettype wire

// ----- src/sshb_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none
module sshb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

// ----- bench/sorted_sparse_histogram_binner_top_test.sv -----
// Self-checking bench for the sorted sparse histogram binner: random and directed traffic
`timescale 1ns / 1ps
`default_nettype none
module sorted_sparse_histogram_binner_top_test;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int DRAIN_CYCLES   = 300;

   typedef struct {
      logic [11:0]          position;
      logic [17:0]          center_a;
      logic [17:0]          center_b;
      logic [31:0]          bin_count;
      logic                 is_new;
      sshb_pkg::status_type status;
      logic [12:0]          bins_used;
   } bin_result_type;

   // Sorted bin table mirror and the queue of results still owed by the block
   class histogram_scoreboard;
      logic [sshb_pkg::KEY_W-1:0]   key_tab[sshb_pkg::MAX_BINS];
      logic [sshb_pkg::COUNT_W-1:0] cnt_tab[sshb_pkg::MAX_BINS];
      int                 used;
      int                 size_a = 1;
      int                 size_b = 1;
      bin_result_type     owed[$];
      int                 errors;
      int                 requests;
      int                 results;
      int                 full_hits;
      int                 range_hits;
      int                 new_bins;

      function int centre_x2(logic signed [15:0] s, int size);
         int w;
         int q;
         w = (size == 0) ? 1 : size;
         q = (int'(s) / w) * w;
         return 2 * q + w;
      endfunction

      function void note_request(logic kind, logic [15:0] a, logic [15:0] b,
                                 logic [11:0] idx);
         bin_result_type   r;
         int               ca;
         int               cb;
         int               lo;
         int               hi;
         int               mid;
         bit               found;
         logic [sshb_pkg::KEY_W-1:0] key;
         requests++;
         r.position  = '0;
         r.center_a  = '0;
         r.center_b  = '0;
         r.bin_count = '0;
         r.is_new    = 1'b0;
         r.status    = sshb_pkg::STATUS_OK;
         if (kind == sshb_pkg::KIND_READ) begin
            r.position = idx;
            if (int'(idx) < used) begin
               r.center_a  = key_tab[idx][sshb_pkg::KEY_W-1:sshb_pkg::CENTER_W]
                             - sshb_pkg::CENTER_BIAS;
               r.center_b  = key_tab[idx][sshb_pkg::CENTER_W-1:0] - sshb_pkg::CENTER_BIAS;
               r.bin_count = cnt_tab[idx];
            end else begin
               r.status = sshb_pkg::STATUS_RANGE;
               range_hits++;
            end
         end else begin
            ca  = centre_x2(a, size_a);
            cb  = centre_x2(b, size_b);
            r.center_a = ca[17:0];
            r.center_b = cb[17:0];
            key = {ca[17:0] + sshb_pkg::CENTER_BIAS, cb[17:0] + sshb_pkg::CENTER_BIAS};
            lo = 0;
            hi = used;
            found = 1'b0;
            while (lo < hi && !found) begin
               mid = (lo + hi) / 2;
               if (key_tab[mid] < key) lo = mid + 1;
               else if (key_tab[mid] > key) hi = mid;
               else begin
                  lo = mid;
                  found = 1'b1;
               end
            end
            if (found) begin
               if (cnt_tab[lo] != sshb_pkg::COUNT_MAX) cnt_tab[lo]++;
               r.position  = lo[11:0];
               r.bin_count = cnt_tab[lo];
            end else if (used >= sshb_pkg::MAX_BINS) begin
               r.status = sshb_pkg::STATUS_FULL;
               full_hits++;
            end else begin
               for (int i = used; i > lo; i--) begin
                  key_tab[i] = key_tab[i-1];
                  cnt_tab[i] = cnt_tab[i-1];
               end
               key_tab[lo] = key;
               cnt_tab[lo] = 1;
               used++;
               new_bins++;
               r.position  = lo[11:0];
               r.bin_count = 1;
               r.is_new    = 1'b1;
            end
         end
         r.bins_used = used[12:0];
         owed.insert(owed.size(), r);
      endfunction

      function void check_result(logic [95:0] d, logic [2:0] u);
         bin_result_type e;
         results++;
         if (owed.size() == 0) begin
            $error("result with nothing outstanding: tdata %h tuser %h", d, u);
            errors++;
            return;
         end
         e = owed.pop_front();
         if (d[11:0] !== e.position) begin
            $error("position exp %0d got %0d", e.position, d[11:0]); errors++;
         end
         if (d[29:12] !== e.center_a) begin
            $error("center_a exp %h got %h", e.center_a, d[29:12]); errors++;
         end
         if (d[47:30] !== e.center_b) begin
            $error("center_b exp %h got %h", e.center_b, d[47:30]); errors++;
         end
         if (d[79:48] !== e.bin_count) begin
            $error("bin_count exp %0d got %0d", e.bin_count, d[79:48]); errors++;
         end
         if (d[92:80] !== e.bins_used) begin
            $error("bins_used exp %0d got %0d", e.bins_used, d[92:80]); errors++;
         end
         if (u[0] !== e.is_new) begin
            $error("is_new exp %0d got %0d", e.is_new, u[0]); errors++;
         end
         if (u[2:1] !== e.status) begin
            $error("status exp %0d got %0d", e.status, u[2:1]); errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;  // sample_a, sample_b, read_index, zero pad
   logic        req_tuser = sshb_pkg::KIND_ADD;  // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;  // position, center_a, center_b, bin_count, bins_used, zero pad
   logic [2:0]  rsp_tuser;  // is_new, status
   logic        csr_we = 1'b0;
   logic        csr_index = sshb_pkg::CSR_BIN_SIZE_A;
   logic [15:0] csr_wdata = '0;

   histogram_scoreboard sb = new();
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int rx_hold = 0;
   int quiet_cycles = 0;

   sorted_sparse_histogram_binner_top u_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Receiver: random back-pressure plus an optional long hold-off
   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rx_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata[15:0], req_tdata[31:16], req_tdata[43:32]);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("sorted_sparse_histogram_binner_top verification failed");
            $finish;
         end
      end
   end

   task automatic send_item(logic kind, logic [15:0] a, logic [15:0] b, logic [11:0] idx);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, idx, b, a};
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
   endtask

   // Only writes with nothing in flight, since it settles first
   task automatic write_size(logic which, logic [15:0] value);
      settle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (which == sshb_pkg::CSR_BIN_SIZE_A) sb.size_a = value;
      else sb.size_b = value;
   endtask

   function automatic logic [15:0] pick_sample(int size);
      int w;
      int span;
      w = (size == 0) ? 1 : size;
      span = (w * 3 > 32767) ? 32767 : w * 3;
      if ($urandom_range(9) == 0) return 16'($urandom);
      return 16'($urandom_range(2 * span) - span);
   endfunction

   function automatic int pick_size();
      case ($urandom_range(3))
         0: return $urandom_range(64);
         1: return $urandom_range(32768, 8192);
         2: return 32768;
         default: return $urandom_range(32768, 4096);
      endcase
   endfunction

   initial begin
      int sa;
      int sb_size;
      int fill_b;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, hits, reads in and out of range, zero size
      send_item(sshb_pkg::KIND_ADD, 16'sd0, 16'sd0, '0);
      send_item(sshb_pkg::KIND_ADD, 16'sd0, 16'sd0, '1);
      send_item(sshb_pkg::KIND_ADD, 16'h8000, 16'h8000, '0);
      send_item(sshb_pkg::KIND_ADD, 16'h7FFF, 16'h7FFF, '0);
      send_item(sshb_pkg::KIND_ADD, 16'hFFFF, 16'h0001, '0);
      send_item(sshb_pkg::KIND_ADD, 16'h7FFF, 16'h8000, '0);
      send_item(sshb_pkg::KIND_READ, 16'hFFFF, 16'hFFFF, 12'd0);
      send_item(sshb_pkg::KIND_READ, '0, '0, 12'd4);
      send_item(sshb_pkg::KIND_READ, '0, '0, 12'd5);
      send_item(sshb_pkg::KIND_READ, '0, '0, 12'hFFF);
      write_size(sshb_pkg::CSR_BIN_SIZE_A, 16'd0);
      write_size(sshb_pkg::CSR_BIN_SIZE_B, 16'd32768);
      send_item(sshb_pkg::KIND_ADD, 16'h8000, 16'h7FFF, '0);
      send_item(sshb_pkg::KIND_ADD, 16'hFFFF, 16'hFFFF, '0);
      send_item(sshb_pkg::KIND_ADD, 16'h0003, 16'h0001, '0);
      write_size(sshb_pkg::CSR_BIN_SIZE_A, 16'd32768);
      write_size(sshb_pkg::CSR_BIN_SIZE_B, 16'd0);
      send_item(sshb_pkg::KIND_ADD, 16'h8000, 16'h8000, '0);
      send_item(sshb_pkg::KIND_ADD, 16'h7FFF, 16'hFFFE, '0);
      send_item(sshb_pkg::KIND_READ, '0, '0, 12'd1);

      // Random: three idling modes, four size settings each
      for (int mode = 0; mode < 3; mode++) begin
         tx_idle_pct = (mode == 0) ? 25 : (mode == 1) ? 83 : 0;
         rx_idle_pct = (mode == 0) ? 83 : (mode == 1) ? 25 : 0;
         for (int setting = 0; setting < 4; setting++) begin
            sa = pick_size();
            sb_size = pick_size();
            write_size(sshb_pkg::CSR_BIN_SIZE_A, sa[15:0]);
            write_size(sshb_pkg::CSR_BIN_SIZE_B, sb_size[15:0]);
            // hold the receiver off so the block backs up and stalls its input
            if (mode == 0 && setting == 0) rx_hold = 600;
            for (int n = 0; n < 110; n++) begin
               if ($urandom_range(3) == 0)
                  send_item(sshb_pkg::KIND_READ, 16'($urandom), 16'($urandom),
                            ($urandom_range(7) == 0) ? 12'($urandom)
                                                     : 12'($urandom_range(sb.used + 3)));
               else
                  send_item(sshb_pkg::KIND_ADD, pick_sample(sa), pick_sample(sb_size),
                            12'($urandom));
            end
         end
      end

      // Add a run of bins near the top of the key range, then mix adds and reads
      tx_idle_pct = 10;
      rx_idle_pct = 10;
      write_size(sshb_pkg::CSR_BIN_SIZE_A, 16'd32767);
      write_size(sshb_pkg::CSR_BIN_SIZE_B, 16'd1);
      fill_b = -32768;
      for (int n = 0; n < 80; n++) begin
         send_item(sshb_pkg::KIND_ADD, 16'h7FFF, 16'(fill_b), '0);
         fill_b++;
      end
      for (int n = 0; n < 12; n++) begin
         send_item(sshb_pkg::KIND_ADD, 16'($urandom), 16'($urandom), '0);
         send_item(sshb_pkg::KIND_READ, '0, '0,
                   ($urandom_range(1) == 0) ? 12'hFFF : 12'($urandom));
      end
      send_item(sshb_pkg::KIND_ADD, 16'h7FFF, 16'h8000, '0);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d requests and %0d results; %0d new bins, %0d bins held at end,",
               sb.requests, sb.results, sb.new_bins, sb.used);
      $display("%0d dropped on a full table, %0d reads past the used bins.",
               sb.full_hits, sb.range_hits);
      if (sb.errors == 0 && sb.owed.size() == 0)
         $display("sorted_sparse_histogram_binner_top verification clean");
      else
         $display("sorted_sparse_histogram_binner_top verification failed");
      $finish;
   end
endmodule
`default_nettype wire
